>>> src/pdf_pkg.sv
// Shared types and constants for the Pareto dominance flagger.
package pdf_pkg;

    localparam int MaxParticles = 64;
    localparam int CostWidth    = 32;
    localparam int FieldWidth   = 32;
    localparam int IndexWidth   = 6;
    localparam int FifoDepth    = 2;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_REPORT
    } back_state_t;

endpackage

>>> src/pdf_front.sv
// Front end: accepts words, converts costs to ordered keys, queues them for the back end.
module pdf_front #(
    parameter int COST_WIDTH = pdf_pkg::CostWidth
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pdf_pkg::FieldWidth-1:0] cost_first,
    input  logic signed [pdf_pkg::FieldWidth-1:0] cost_second,
    input  logic signed [pdf_pkg::FieldWidth-1:0] cost_third,
    input  logic                                batch_end,
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic [3*COST_WIDTH-1:0]             q_keys,
    output logic                                q_end
);
    import pdf_pkg::*;

    localparam int PtrW = $clog2(FifoDepth);

    logic [3*COST_WIDTH-1:0] key_mem [FifoDepth];
    logic                    end_mem [FifoDepth];
    logic [PtrW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]           fill_reg, fill_next;
    logic                    push, pop;
    logic [3*COST_WIDTH-1:0] in_keys;

    function automatic logic [COST_WIDTH-1:0] order_key(input logic [FieldWidth-1:0] raw);
        logic [COST_WIDTH-1:0] v;
        v = COST_WIDTH'(raw);
        v[COST_WIDTH-1] = ~v[COST_WIDTH-1];
        return v;
    endfunction

    assign in_keys = {order_key(cost_third), order_key(cost_second), order_key(cost_first)};
    assign in_ready = (fill_reg != (PtrW+1)'(FifoDepth));
    assign push = in_valid && in_ready;
    assign q_valid = (fill_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_keys = key_mem[rd_ptr_reg];
    assign q_end = end_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next = fill_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            key_mem[wr_ptr_reg] <= in_keys;
            end_mem[wr_ptr_reg] <= batch_end;
        end
    end

endmodule

>>> src/pdf_back.sv
// Back end: compare cells over stored particles, marks, and result sequencing.
module pdf_back #(
    parameter int MAX_PARTICLES = pdf_pkg::MaxParticles,
    parameter int COST_WIDTH    = pdf_pkg::CostWidth
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_data,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic [3*COST_WIDTH-1:0]         q_keys,
    input  logic                            q_end,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pdf_pkg::IndexWidth-1:0]  particle_index,
    output logic                            is_dominated,
    output logic                            overflow,
    output logic                            run_end
);
    import pdf_pkg::*;

    localparam int CntW = $clog2(MAX_PARTICLES + 1);
    localparam int IdxW = $clog2(MAX_PARTICLES);

    logic [3*COST_WIDTH-1:0]  cells_reg [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0] marks_reg, marks_next;
    logic [CntW-1:0]          count_reg, count_next;
    logic [CntW-1:0]          rpt_reg, rpt_next;
    logic                     ovf_reg, ovf_next;
    logic [1:0]               obj_reg;
    back_state_t              state_reg, state_next;
    logic                     out_valid_reg, out_valid_next;
    logic [IndexWidth-1:0]    idx_reg, idx_next;
    logic                     dom_reg, dom_next;
    logic                     ovfo_reg, ovfo_next;
    logic                     end_reg, end_next;
    logic [MAX_PARTICLES-1:0] new_dom, old_dom;
    logic                     take, store, out_free;
    logic [1:0]               used;

    function automatic logic no_better(input logic [3*COST_WIDTH-1:0] a,
                                       input logic [3*COST_WIDTH-1:0] b,
                                       input logic [1:0] n);
        logic r;
        r = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < n && a[k*COST_WIDTH +: COST_WIDTH] < b[k*COST_WIDTH +: COST_WIDTH])
                r = 1'b0;
        end
        return r;
    endfunction

    assign used = (obj_reg == 2'd0) ? 2'd1 : obj_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_PARTICLES; j++)
        begin
            new_dom[j] = (CntW'(j) < count_reg) && no_better(q_keys, cells_reg[j], used);
            old_dom[j] = (CntW'(j) < count_reg) && no_better(cells_reg[j], q_keys, used);
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign q_ready = (state_reg == BK_LOAD);
    assign take = q_valid && q_ready;
    assign store = take && (count_reg != CntW'(MAX_PARTICLES));

    always_comb
    begin
        state_next = state_reg;
        marks_next = marks_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        rpt_next = rpt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        idx_next = idx_reg;
        dom_next = dom_reg;
        ovfo_next = ovfo_reg;
        end_next = end_reg;
        case (state_reg)
            BK_LOAD:
            begin
                if (take)
                begin
                    if (store)
                    begin
                        marks_next = marks_reg | old_dom;
                        marks_next[count_reg[IdxW-1:0]] = |new_dom;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (q_end)
                    begin
                        rpt_next = '0;
                        state_next = BK_REPORT;
                    end
                end
            end
            BK_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    idx_next = IndexWidth'(rpt_reg);
                    dom_next = marks_reg[rpt_reg[IdxW-1:0]];
                    ovfo_next = ovf_reg;
                    end_next = (rpt_reg + 1'b1 == count_reg);
                    rpt_next = rpt_reg + 1'b1;
                    if (rpt_reg + 1'b1 == count_reg)
                    begin
                        marks_next = '0;
                        count_next = '0;
                        ovf_next = 1'b0;
                        state_next = BK_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_LOAD;
            marks_reg <= '0;
            count_reg <= '0;
            rpt_reg <= '0;
            ovf_reg <= 1'b0;
            obj_reg <= 2'd3;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            marks_reg <= marks_next;
            count_reg <= count_next;
            rpt_reg <= rpt_next;
            ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                obj_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        dom_reg <= dom_next;
        ovfo_reg <= ovfo_next;
        end_reg <= end_next;
        if (store)
            cells_reg[count_reg[IdxW-1:0]] <= q_keys;
    end

    assign out_valid = out_valid_reg;
    assign particle_index = idx_reg;
    assign is_dominated = dom_reg;
    assign overflow = ovfo_reg;
    assign run_end = end_reg;

endmodule

>>> src/pareto_dominance_flagger.sv
// Top level of the Pareto dominance flagger.
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    cost_first, cost_second, cost_third, batch_end
//   out       output     out_valid/out_ready  particle_index, is_dominated, overflow, run_end
//   cfg       input      cfg_we               cfg_data (objectives_in_use)
// Loading takes a word per cycle unless stalled; each is compared with all stored cells at once.
// batch_end starts reporting: one result per cycle if not stalled, count results; input waits.
// Reset clears the batch and sets objectives_in_use to 3.
// A two-entry queue lets the input side keep taking words while the back end stalls, until full.
module pareto_dominance_flagger #(
    parameter int MAX_PARTICLES = pdf_pkg::MaxParticles,
    parameter int COST_WIDTH    = pdf_pkg::CostWidth
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pdf_pkg::FieldWidth-1:0] cost_first,
    input  logic signed [pdf_pkg::FieldWidth-1:0] cost_second,
    input  logic signed [pdf_pkg::FieldWidth-1:0] cost_third,
    input  logic                                  batch_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [pdf_pkg::IndexWidth-1:0]        particle_index,
    output logic                                  is_dominated,
    output logic                                  overflow,
    output logic                                  run_end
);
    import pdf_pkg::*;

    logic                    q_valid, q_ready, q_end;
    logic [3*COST_WIDTH-1:0] q_keys;

    pdf_front #(.COST_WIDTH(COST_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cost_first(cost_first), .cost_second(cost_second), .cost_third(cost_third),
        .batch_end(batch_end),
        .q_valid(q_valid), .q_ready(q_ready), .q_keys(q_keys), .q_end(q_end)
    );

    pdf_back #(.MAX_PARTICLES(MAX_PARTICLES), .COST_WIDTH(COST_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_keys(q_keys), .q_end(q_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .particle_index(particle_index), .is_dominated(is_dominated),
        .overflow(overflow), .run_end(run_end)
    );

endmodule

>>> src/pdf_checker.sv
// Port-level checker for the Pareto dominance flagger, with its bind.
module pdf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [pdf_pkg::IndexWidth-1:0]     particle_index,
    input logic                               overflow,
    input logic                               run_end
);
    import pdf_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(particle_index))
        else $error("output word changed while stalled");

    a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_end ##1 out_valid |->
        particle_index == $past(particle_index) + 1'b1)
        else $error("result index not consecutive");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && run_end ##1 out_valid |-> particle_index == '0)
        else $error("batch does not start at index zero");

    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_end ##1 out_valid |-> overflow == $past(overflow))
        else $error("overflow flag changed inside batch");

endmodule

bind pareto_dominance_flagger pdf_checker u_pdf_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_valid), .out_ready(out_ready),
    .particle_index(particle_index), .overflow(overflow), .run_end(run_end)
);

>>> tb/tb_pareto_dominance_flagger.sv
// Self-checking testbench for the Pareto dominance flagger: random batches, config sweep.
`timescale 1ns / 100ps

module tb_pareto_dominance_flagger;
    import pdf_pkg::*;

    typedef struct packed {
        logic signed [FieldWidth-1:0] c0;
        logic signed [FieldWidth-1:0] c1;
        logic signed [FieldWidth-1:0] c2;
        logic                         last;
    } cost_word_t;

    typedef struct packed {
        logic [IndexWidth-1:0] idx;
        logic                  dom;
        logic                  ovf;
        logic                  fin;
    } flag_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_data = 2'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [FieldWidth-1:0] cost_first = '0, cost_second = '0, cost_third = '0;
    logic batch_end = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [IndexWidth-1:0] particle_index;
    logic is_dominated, overflow, run_end;

    cost_word_t pending_words[$];
    flag_t      expected_flags[$];
    int tx_idle = 19, rx_idle = 48;
    int hold_left = 0;
    bit hold_go = 0;
    int errors = 0, words_sent = 0, flags_seen = 0, batches = 0;

    logic signed [FieldWidth-1:0] stored_cost[MaxParticles][3];
    bit  dom_mark[MaxParticles];
    int  stored_n = 0;
    bit  ovf_seen = 0;
    logic [1:0] objectives = 2'd3;

    pareto_dominance_flagger DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cost_first(cost_first), .cost_second(cost_second), .cost_third(cost_third),
        .batch_end(batch_end), .out_valid(out_valid), .out_ready(out_ready),
        .particle_index(particle_index), .is_dominated(is_dominated),
        .overflow(overflow), .run_end(run_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // true if a is no better than b in every objective in use
    function automatic bit no_better(input logic signed [FieldWidth-1:0] a[3],
                                     input logic signed [FieldWidth-1:0] b[3]);
        int used;
        used = (objectives == 0) ? 1 : objectives;
        for (int k = 0; k < used; k++)
            if (a[k] < b[k])
                return 0;
        return 1;
    endfunction

    function automatic void predict_flags(input cost_word_t w);
        logic signed [FieldWidth-1:0] v[3];
        flag_t f;
        v[0] = w.c0;
        v[1] = w.c1;
        v[2] = w.c2;
        if (stored_n < MaxParticles)
        begin
            dom_mark[stored_n] = 0;
            for (int j = 0; j < stored_n; j++)
            begin
                if (no_better(v, stored_cost[j]))
                    dom_mark[stored_n] = 1;
                if (no_better(stored_cost[j], v))
                    dom_mark[j] = 1;
            end
            stored_cost[stored_n] = v;
            stored_n++;
        end
        else
            ovf_seen = 1;
        if (w.last)
        begin
            for (int j = 0; j < stored_n; j++)
            begin
                f.idx = j[IndexWidth-1:0];
                f.dom = dom_mark[j];
                f.ovf = ovf_seen;
                f.fin = (j + 1 == stored_n);
                expected_flags.push_back(f);
            end
            for (int j = 0; j < MaxParticles; j++)
                dom_mark[j] = 0;
            stored_n = 0;
            ovf_seen = 0;
            batches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= tx_idle)
            begin
                cost_word_t w;
                w = pending_words.pop_front();
                cost_first  <= w.c0;
                cost_second <= w.c1;
                cost_third  <= w.c2;
                batch_end   <= w.last;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_go)
        begin
            hold_go = 0;
            hold_left <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predict_flags('{cost_first, cost_second, cost_third, batch_end});
            words_sent++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            flags_seen++;
            if (expected_flags.size() == 0)
            begin
                $error("unexpected result index %0d", particle_index);
                errors++;
            end
            else
            begin
                flag_t e;
                e = expected_flags.pop_front();
                if (particle_index !== e.idx)
                begin
                    $error("particle_index exp %0d got %0d", e.idx, particle_index);
                    errors++;
                end
                if (is_dominated !== e.dom)
                begin
                    $error("is_dominated exp %0d got %0d", e.dom, is_dominated);
                    errors++;
                end
                if (overflow !== e.ovf)
                begin
                    $error("overflow exp %0d got %0d", e.ovf, overflow);
                    errors++;
                end
                if (run_end !== e.fin)
                begin
                    $error("run_end exp %0d got %0d", e.fin, run_end);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [FieldWidth-1:0] rand_cost();
        case ($urandom_range(9))
            0: return {1'b1, {(FieldWidth-1){1'b0}}};
            1: return {1'b0, {(FieldWidth-1){1'b1}}};
            2, 3, 4: return $urandom;
            default: return $signed($urandom_range(8)) - 4;
        endcase
    endfunction

    task automatic add_word(input logic signed [FieldWidth-1:0] a, b, c, input bit last);
        pending_words.push_back('{a, b, c, last});
    endtask

    task automatic add_batch(input int n);
        for (int i = 0; i < n; i++)
            add_word(rand_cost(), rand_cost(), rand_cost(), i == n - 1);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_flags.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_objectives(input logic [1:0] v);
        @(posedge clk);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        objectives = v;
    endtask

    initial
    begin
        logic [1:0] sweep[5];
        sweep = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone particle, extremes, duplicates
        add_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
        add_word(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        add_word(32'sh7fffffff, 32'sh80000000, 32'sh0, 0);
        add_word(32'sh7fffffff, 32'sh80000000, 32'sh0, 0);
        add_word(32'sh0, 32'sh7fffffff, 32'sh80000000, 1);
        add_word(-1, 5, 2, 0);
        add_word(5, -1, 2, 0);
        add_word(2, 2, -1, 1);
        add_batch(6);
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            write_objectives(sweep[p]);
            if (p == 1)
            begin
                tx_idle = 48;
                rx_idle = 19;
            end
            if (p == 3)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            if (p == 2)
            begin
                // fill past capacity; the closing word itself is dropped
                hold_go = 1;
                add_batch(66);
                // keep offering words while results are held back
                add_batch(8);
            end
            while (pending_words.size() < 8)
                add_batch($urandom_range(1, 8));
            wait_drained();
        end

        $display("%0d words in %0d batches, %0d results checked, objectives 0..3 swept",
                 words_sent, batches, flags_seen);
        if (errors == 0)
            $display("pareto_dominance_flagger: match");
        else
            $display("pareto_dominance_flagger: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("pareto_dominance_flagger: mismatch");
        $finish;
    end

endmodule
